FILE: design/rtk_pkg.sv
// ----------------------------------------------------------------------------
// rtk_pkg
// Shared widths, request and status codes and the cell control word for the
// ranked top-k table.
// ----------------------------------------------------------------------------
package rtk_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int SCORE_WIDTH_DEF = 32;
  localparam int TAG_WIDTH_DEF   = 32;

  localparam int TYPE_W = 3;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int ST_W   = 2;

  localparam int TABLE_SIZE_RESET = 16;

  localparam logic [TYPE_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_CHECK  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_READ   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_SETTAG = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOPLACE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic             clear;
    logic             add;
    logic             set_tag;
    logic             remove;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] idx;
  } cell_ctrl_t;

endpackage

FILE: design/rtk_req_if.sv
// ----------------------------------------------------------------------------
// rtk_req_if
// Request channel: valid/ready with one request word.
// ----------------------------------------------------------------------------
interface rtk_req_if #(
  parameter int SCORE_WIDTH = rtk_pkg::SCORE_WIDTH_DEF,
  parameter int TAG_WIDTH   = rtk_pkg::TAG_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [rtk_pkg::TYPE_W-1:0]     req_type;
  logic [SCORE_WIDTH-1:0]         score;
  logic [TAG_WIDTH-1:0]           name_tag;
  logic [rtk_pkg::IDX_W-1:0]      index;

  modport source (output valid, req_type, score, name_tag, index, input ready);
  modport sink   (input valid, req_type, score, name_tag, index, output ready);
endinterface

FILE: design/rtk_rsp_if.sv
// ----------------------------------------------------------------------------
// rtk_rsp_if
// Response channel: valid/ready with one result word.
// ----------------------------------------------------------------------------
interface rtk_rsp_if #(
  parameter int SCORE_WIDTH = rtk_pkg::SCORE_WIDTH_DEF,
  parameter int TAG_WIDTH   = rtk_pkg::TAG_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [rtk_pkg::ST_W-1:0]   status;
  logic [rtk_pkg::IDX_W-1:0]  position;
  logic [SCORE_WIDTH-1:0]     entry_score;
  logic [TAG_WIDTH-1:0]       entry_tag;
  logic [rtk_pkg::CNT_W-1:0]  entries_now;

  modport source (output valid, status, position, entry_score, entry_tag, entries_now,
                  input ready);
  modport sink   (input valid, status, position, entry_score, entry_tag, entries_now,
                  output ready);
endinterface

FILE: design/rtk_cfg_if.sv
// ----------------------------------------------------------------------------
// rtk_cfg_if
// Configuration write channel: valid/ready with the table size word.
// ----------------------------------------------------------------------------
interface rtk_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rtk_pkg::CNT_W-1:0]  table_size;

  modport source (output valid, table_size, input ready);
  modport sink   (input valid, table_size, output ready);
endinterface

FILE: design/rtk_cell.sv
// ----------------------------------------------------------------------------
// rtk_cell
// One rank of the table: holds a score/tag pair, compares against the
// broadcast score and takes its left or right neighbor on add and remove.
// ----------------------------------------------------------------------------
module rtk_cell #(
  parameter int POS         = 0,
  parameter int SCORE_WIDTH = rtk_pkg::SCORE_WIDTH_DEF,
  parameter int TAG_WIDTH   = rtk_pkg::TAG_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rtk_pkg::cell_ctrl_t     ctrl,
  input  logic [SCORE_WIDTH-1:0]  new_score,
  input  logic [TAG_WIDTH-1:0]    new_tag,
  input  logic                    prev_place,
  input  logic [SCORE_WIDTH-1:0]  prev_score,
  input  logic [TAG_WIDTH-1:0]    prev_tag,
  input  logic                    next_live,
  input  logic [SCORE_WIDTH-1:0]  next_score,
  input  logic [TAG_WIDTH-1:0]    next_tag,
  output logic [SCORE_WIDTH-1:0]  score,
  output logic [TAG_WIDTH-1:0]    tag,
  output logic                    live,
  output logic                    place,
  output logic                    hit
);
  import rtk_pkg::*;

  logic [SCORE_WIDTH-1:0] score_next;
  logic [TAG_WIDTH-1:0]   tag_next;

  assign live  = POS < int'(ctrl.count);
  assign place = live && (score < new_score);
  assign hit   = live && (POS == int'(ctrl.idx));

  always_comb begin
    score_next = score;
    tag_next   = tag;
    if (ctrl.clear) begin
      score_next = '0;
      tag_next   = '0;
    end else if (ctrl.add && place) begin
      // live scores are descending, so a placing left neighbor means shift
      if (prev_place) begin
        score_next = prev_score;
        tag_next   = prev_tag;
      end else begin
        score_next = new_score;
        tag_next   = new_tag;
      end
    end else if (ctrl.set_tag && hit) begin
      tag_next = new_tag;
    end else if (ctrl.remove && live && (POS >= int'(ctrl.idx))) begin
      if (next_live) begin
        score_next = next_score;
        tag_next   = next_tag;
      end else begin
        score_next = '0;
        tag_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
      tag   <= '0;
    end else begin
      score <= score_next;
      tag   <= tag_next;
    end
  end

endmodule

FILE: design/ranked_topk_table.sv
// ----------------------------------------------------------------------------
// ranked_topk_table
// Descending-score table of score/tag pairs built as a row of rank cells.
//
//   channel  dir  handshake     word
//   req      in   valid/ready   req_type, score, name_tag, index
//   rsp      out  valid/ready   status, position, entry_score, entry_tag,
//                               entries_now
//   cfg      in   valid/ready   table_size (always ready)
//
// All cells compare in parallel and shift to a neighbor at the same edge
// that loads the result into the response register. One request per cycle
// while rsp.ready is high. req.ready drops only while a response is held
// and not taken. Reset and a table_size write clear all cells.
// ----------------------------------------------------------------------------
module ranked_topk_table #(
  parameter int SCORE_WIDTH = rtk_pkg::SCORE_WIDTH_DEF,
  parameter int TAG_WIDTH   = rtk_pkg::TAG_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst,
  rtk_req_if.sink   req,
  rtk_rsp_if.source rsp,
  rtk_cfg_if.sink   cfg
);
  import rtk_pkg::*;

  localparam int DEPTH     = DEPTH_DEF;
  localparam int CNT_RESET = (TABLE_SIZE_RESET > DEPTH) ? DEPTH : TABLE_SIZE_RESET;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  cell_ctrl_t              ctrl;
  logic                    req_fire;
  logic                    cfg_fire;
  logic                    in_range;

  // index 0 and DEPTH+1 are the zero neighbors past both ends
  logic [SCORE_WIDTH-1:0]  cs [DEPTH+2];
  logic [TAG_WIDTH-1:0]    ct [DEPTH+2];
  logic [DEPTH+1:0]        pv;
  logic [DEPTH+1:0]        lv;
  logic [DEPTH-1:0]        hv;
  logic [DEPTH-1:0]        first;

  logic [ST_W-1:0]         st;
  logic [IDX_W-1:0]        pos;
  logic [SCORE_WIDTH-1:0]  rd_score;
  logic [TAG_WIDTH-1:0]    rd_tag;

  assign req.ready = !rsp.valid || rsp.ready;
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign in_range  = {1'b0, req.index} < count;

  assign ctrl.clear   = cfg_fire;
  assign ctrl.add     = req_fire && (req.req_type == REQ_ADD);
  assign ctrl.set_tag = req_fire && (req.req_type == REQ_SETTAG);
  assign ctrl.remove  = req_fire && (req.req_type == REQ_REMOVE);
  assign ctrl.count   = count;
  assign ctrl.idx     = req.index;

  assign cs[0]       = '0;
  assign ct[0]       = '0;
  assign cs[DEPTH+1] = '0;
  assign ct[DEPTH+1] = '0;
  assign pv[0]       = 1'b0;
  assign pv[DEPTH+1] = 1'b0;
  assign lv[0]       = 1'b0;
  assign lv[DEPTH+1] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rtk_cell #(
      .POS         (g),
      .SCORE_WIDTH (SCORE_WIDTH),
      .TAG_WIDTH   (TAG_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_score  (req.score),
      .new_tag    (req.name_tag),
      .prev_place (pv[g]),
      .prev_score (cs[g]),
      .prev_tag   (ct[g]),
      .next_live  (lv[g+2]),
      .next_score (cs[g+2]),
      .next_tag   (ct[g+2]),
      .score      (cs[g+1]),
      .tag        (ct[g+1]),
      .live       (lv[g+1]),
      .place      (pv[g+1]),
      .hit        (hv[g])
    );
    assign first[g] = pv[g+1] && !pv[g];
  end

  always_comb begin
    pos      = '0;
    rd_score = '0;
    rd_tag   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        pos = pos | IDX_W'(i);
      end
      if (hv[i]) begin
        rd_score = rd_score | cs[i+1];
        rd_tag   = rd_tag | ct[i+1];
      end
    end
  end

  always_comb begin
    st         = ST_OK;
    count_next = count;
    unique case (req.req_type) inside
      REQ_ADD, REQ_CHECK: begin
        if (first == '0) begin
          st = ST_NOPLACE;
        end
      end
      REQ_READ, REQ_SETTAG: begin
        if (!in_range) begin
          st = ST_RANGE;
        end
      end
      REQ_REMOVE: begin
        if (!in_range) begin
          st = ST_RANGE;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(CNT_RESET);
    end else if (cfg_fire) begin
      if (int'(cfg.table_size) > DEPTH) begin
        count <= CNT_W'(DEPTH);
      end else begin
        count <= cfg.table_size;
      end
    end else if (req_fire) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.status      <= st;
      rsp.position    <= ((req.req_type == REQ_ADD || req.req_type == REQ_CHECK) &&
                          st == ST_OK) ? pos : '0;
      rsp.entry_score <= (req.req_type == REQ_READ && st == ST_OK) ? rd_score : '0;
      rsp.entry_tag   <= (req.req_type == REQ_READ && st == ST_OK) ? rd_tag : '0;
      rsp.entries_now <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("live count exceeds table depth");

  a_one_insert: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first))
    else $error("more than one insertion rank");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    req_fire && !cfg_fire && req.req_type == REQ_REMOVE && in_range
    |=> count == $past(count) - CNT_W'(1))
    else $error("remove did not lower the count");

  for (genvar g = 1; g < DEPTH; g++) begin : g_order
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      lv[g+1] |-> cs[g] >= cs[g+1])
      else $error("live scores out of order");
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for ranked_topk_table. A short directed run covers ties, empty
// and full tables, range errors and unused request types; random runs then
// go through several table sizes with both sides idling at random.
// Every response word is checked against a cycle-free model of the table.
// ----------------------------------------------------------------------------
module testbench;
  import rtk_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int SW    = SCORE_WIDTH_DEF;
  localparam int TW    = TAG_WIDTH_DEF;

  localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam int HOLD_LEN    = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_SIZE  [NUM_PHASES] = '{16, 0, 31, 3, 20, 1, 16, 8};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{300, 60, 300, 250, 300, 120, 350, 300};

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [SW-1:0]     score;
    logic [TW-1:0]     tag;
    logic [IDX_W-1:0]  index;
  } rank_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] position;
    logic [SW-1:0]    entry_score;
    logic [TW-1:0]    entry_tag;
    logic [CNT_W-1:0] entries_now;
  } rank_rsp_t;

  class topk_board;
    logic [SW-1:0] scores [DEPTH];
    logic [TW-1:0] tags [DEPTH];
    int            live;
    rank_rsp_t     due_outcomes[$];
    int            errors;

    function new();
      errors = 0;
      refill(TABLE_SIZE_RESET);
    endfunction

    function void refill(int size);
      live = (size > DEPTH) ? DEPTH : size;
      foreach (scores[i]) begin
        scores[i] = '0;
        tags[i]   = '0;
      end
    endfunction

    function rank_rsp_t rank_outcome(rank_req_t r);
      rank_rsp_t o;
      int        slot;
      o = '0;
      o.status = ST_OK;
      slot = -1;
      case (r.kind) inside
        REQ_ADD, REQ_CHECK: begin
          for (int i = 0; i < live; i++)
            if (slot < 0 && scores[i] < r.score) slot = i;
          if (slot < 0) begin
            o.status = ST_NOPLACE;
          end else begin
            o.position = slot[IDX_W-1:0];
            if (r.kind == REQ_ADD) begin
              for (int i = live - 1; i > slot; i--) begin
                scores[i] = scores[i-1];
                tags[i]   = tags[i-1];
              end
              scores[slot] = r.score;
              tags[slot]   = r.tag;
            end
          end
        end
        REQ_READ, REQ_SETTAG, REQ_REMOVE: begin
          if (int'(r.index) >= live) begin
            o.status = ST_RANGE;
          end else if (r.kind == REQ_READ) begin
            o.entry_score = scores[r.index];
            o.entry_tag   = tags[r.index];
          end else if (r.kind == REQ_SETTAG) begin
            tags[r.index] = r.tag;
          end else begin
            for (int i = int'(r.index); i < live - 1; i++) begin
              scores[i] = scores[i+1];
              tags[i]   = tags[i+1];
            end
            scores[live-1] = '0;
            tags[live-1]   = '0;
            live--;
          end
        end
        default: ;
      endcase
      o.entries_now = live[CNT_W-1:0];
      return o;
    endfunction

    function void note_request(rank_req_t r);
      due_outcomes = {due_outcomes, rank_outcome(r)};
    endfunction

    function void compare_field(string what, logic [63:0] want_v, logic [63:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, what, want_v, got_v);
      end
    endfunction

    function void check_result(rank_rsp_t got);
      rank_rsp_t want;
      if (due_outcomes.size() == 0) begin
        errors++;
        $display("[%0t] unexpected response: expected none, actual %0h", $time, got);
        return;
      end
      want = due_outcomes.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("position", 64'(want.position), 64'(got.position));
      compare_field("entry_score", 64'(want.entry_score), 64'(got.entry_score));
      compare_field("entry_tag", 64'(want.entry_tag), 64'(got.entry_tag));
      compare_field("entries_now", 64'(want.entries_now), 64'(got.entries_now));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rtk_req_if req_ch ();
  rtk_rsp_if rsp_ch ();
  rtk_cfg_if cfg_ch ();

  ranked_topk_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  topk_board sb = new();

  int src_idle_pct  = 15;
  int sink_idle_pct = 88;
  int hold_asked    = 0;
  int quiet_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(rank_req_t'{req_ch.req_type, req_ch.score, req_ch.name_tag,
                                    req_ch.index});
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rank_rsp_t'{rsp_ch.status, rsp_ch.position, rsp_ch.entry_score,
                                    rsp_ch.entry_tag, rsp_ch.entries_now});
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ranked_topk_table regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // response side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic rank_req_t mk(logic [TYPE_W-1:0] kind, logic [SW-1:0] score,
                                   logic [TW-1:0] tag, logic [IDX_W-1:0] index);
    return rank_req_t'{kind, score, tag, index};
  endfunction

  function automatic rank_req_t random_request();
    rank_req_t r;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 38)      r.kind = REQ_ADD;
    else if (pick < 53) r.kind = REQ_CHECK;
    else if (pick < 73) r.kind = REQ_READ;
    else if (pick < 85) r.kind = REQ_SETTAG;
    else if (pick < 92) r.kind = REQ_REMOVE;
    else                r.kind = TYPE_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    case ($urandom_range(9)) inside
      [0:4]:   r.score = $urandom_range(20);
      [5:6]:   r.score = $urandom();
      7:       r.score = '1;
      8:       r.score = '0;
      default: r.score = sb.scores[IDX_W'($urandom_range(DEPTH - 1))];
    endcase
    r.tag = $urandom();
    if (sb.live > 0 && $urandom_range(9) < 8) r.index = IDX_W'($urandom_range(sb.live - 1));
    else                                      r.index = IDX_W'($urandom_range(DEPTH - 1));
    return r;
  endfunction

  task automatic send_item(rank_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.score    <= r.score;
    req_ch.name_tag <= r.tag;
    req_ch.index    <= r.index;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_table_size(logic [CNT_W-1:0] size);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.table_size <= size;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.refill(int'(size));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rank_req_t r;
    int        sent;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_ADD;
    req_ch.score      = '0;
    req_ch.name_tag   = '0;
    req_ch.index      = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.table_size = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // full table of zeros after reset
    send_item(mk(REQ_READ,   '0,  '0, 4'd0));
    send_item(mk(REQ_CHECK,  '0,  '0, 4'd0));
    send_item(mk(REQ_ADD,    '0,  '1, 4'd0));
    send_item(mk(REQ_ADD,    '1,  '1, 4'd0));
    send_item(mk(REQ_CHECK,  '1,  '0, 4'd0));
    send_item(mk(REQ_ADD,    5,   1,  4'd0));
    send_item(mk(REQ_ADD,    5,   2,  4'd0));
    send_item(mk(REQ_ADD,    1,   3,  4'd0));
    send_item(mk(REQ_READ,   '0,  '0, 4'd2));
    send_item(mk(REQ_SETTAG, '0,  32'hA5A5A5A5, 4'd1));
    send_item(mk(REQ_READ,   '0,  '0, 4'd1));
    send_item(mk(REQ_SETTAG, '0,  32'h5A5A5A5A, 4'd15));
    send_item(mk(REQ_READ,   '0,  '0, 4'd15));
    send_item(mk(REQ_REMOVE, '0,  '0, 4'd0));
    send_item(mk(REQ_REMOVE, '0,  '0, 4'd15));
    send_item(mk(REQ_REMOVE, '0,  '0, 4'd14));
    send_item(mk(REQ_READ,   '0,  '0, 4'd14));
    send_item(mk(REQ_UNUSED_LO, '1, '1, 4'd3));
    send_item(mk(REQ_UNUSED_HI, '1, '1, 4'd15));

    // one-entry table: full, tie, and empty cases
    drain_results();
    write_table_size(5'd1);
    send_item(mk(REQ_ADD,    '0,  9,  4'd0));
    send_item(mk(REQ_ADD,    7,   7,  4'd0));
    send_item(mk(REQ_ADD,    7,   8,  4'd0));
    send_item(mk(REQ_CHECK,  8,   '0, 4'd0));
    send_item(mk(REQ_READ,   '0,  '0, 4'd1));
    send_item(mk(REQ_REMOVE, '0,  '0, 4'd0));
    send_item(mk(REQ_ADD,    9,   9,  4'd0));
    send_item(mk(REQ_READ,   '0,  '0, 4'd0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_table_size(CNT_W'(PHASE_SIZE[ph]));
      if (ph == 3) begin
        src_idle_pct  = 88;
        sink_idle_pct = 15;
      end else if (ph == 6) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_asked++;
      end
      sent = 0;
      while (sent < PHASE_ITEMS[ph]) begin
        r = random_request();
        send_item(r);
        sent++;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ranked_topk_table regression: pass");
    end else begin
      $display("ranked_topk_table regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/rtk_pkg.sv
design/rtk_req_if.sv
design/rtk_rsp_if.sv
design/rtk_cfg_if.sv
design/rtk_cell.sv
design/ranked_topk_table.sv
sim/testbench.sv
